// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RTB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTB_ASSERT(label, clk, rst_n, prop, msg)
`define RTB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/rtb_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-body derivative package
// Word format, mass ratio register constants and transaction payload types.
// ----------------------------------------------------------------------------
package rtb_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;
  localparam int MR_BITS   = 24;
  localparam logic [MR_BITS-1:0] MR_RESET = 24'd205982;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] vel_x;
    logic signed [WORD_BITS-1:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] rate_x;
    logic signed [WORD_BITS-1:0] rate_y;
    logic signed [WORD_BITS-1:0] accel_x;
    logic signed [WORD_BITS-1:0] accel_y;
    logic                        saturated;
  } out_t;

endpackage

// ===== hdl/rtb_delay.sv =====
// ----------------------------------------------------------------------------
// Delay line
// Fixed-depth register chain that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module rtb_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

// ===== hdl/rtb_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; the floor of the square root after RW stages.
// ----------------------------------------------------------------------------
module rtb_isqrt #(
  parameter int IN_BITS = 65,
  localparam int RW = (IN_BITS + 1) / 2
) (
  input  logic               clk,
  input  logic [IN_BITS-1:0] rad,
  output logic [RW-1:0]      root
);

  localparam int TW = 2 * RW;

  logic [TW-1:0] rem_r  [RW+1];
  logic [RW-1:0] root_r [RW+1];

  assign rem_r[0]  = TW'(rad);
  assign root_r[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [TW-1:0] trial;
    logic          ge;
    assign trial = (TW'(root_r[k]) << (B + 1)) + (TW'(1) << (2 * B));
    assign ge    = rem_r[k] >= trial;
    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? rem_r[k] - trial : rem_r[k];
      root_r[k+1] <= ge ? (root_r[k] | (RW'(1) << B)) : root_r[k];
    end
  end

  assign root = root_r[RW];

endmodule

// ===== hdl/rtb_udiv.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, NUM_BITS stages deep.
// ----------------------------------------------------------------------------
module rtb_udiv #(
  parameter int NUM_BITS = 57,
  parameter int DEN_BITS = 50
) (
  input  logic                clk,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [NUM_BITS-1:0] quo
);

  logic [DEN_BITS-1:0] rem_r [NUM_BITS+1];
  logic [NUM_BITS-1:0] nq_r  [NUM_BITS+1];
  logic [DEN_BITS-1:0] den_r [NUM_BITS+1];

  assign rem_r[0] = '0;
  assign nq_r[0]  = num;
  assign den_r[0] = den;

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
    logic [DEN_BITS:0] trial;
    logic              ge;
    logic [DEN_BITS:0] diff;
    assign trial = {rem_r[k], nq_r[k][NUM_BITS-1]};
    assign ge    = trial >= {1'b0, den_r[k]};
    assign diff  = trial - {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      nq_r[k+1]  <= {nq_r[k][NUM_BITS-2:0], ge};
      den_r[k+1] <= den_r[k];
    end
  end

  assign quo = nq_r[NUM_BITS];

endmodule

// ===== hdl/restricted_three_body_derivative.sv =====
// Throughput: one transaction per cycle; busy is never raised.
// The depth comes from the 33-stage square root and the 57-stage divider.
// Synchronous reset clears the valid pipeline and loads the default mass ratio.
// Results are never held back, since the receiver cannot stall.
// ----------------------------------------------------------------------------
// Restricted three-body derivative
// Rotating-frame derivative of the planar circular restricted three-body state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module restricted_three_body_derivative
  import rtb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_t                in_data,
  output logic               out_valid,
  output out_t               out_data,
  input  logic               cfg_wr_en,
  input  logic [MR_BITS-1:0] cfg_wr_data
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int SB   = 2 * W + 1;
  localparam int RW   = (SB + 1) / 2;
  localparam int DB   = SB - F;
  localparam int HALF = (DB + 1) / 2;
  localparam int PW   = DB + RW;
  localparam int CB   = PW - F;
  localparam int DEN  = (CB > 64) ? 64 : CB;
  localparam int NB   = F + 1 + W;
  localparam int LAT  = 8 + RW + NB;
  localparam logic [NB-1:0] QMAX = {{(NB-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0]  x;
    logic [W-1:0]  y;
    logic [W-1:0]  vx;
    logic [W-1:0]  vy;
    logic          n1;
    logic          n2;
    logic          ny;
    logic [NB-1:0] num1x;
    logic [NB-1:0] num2x;
    logic [NB-1:0] num1y;
    logic [NB-1:0] num2y;
  } side_t;

  typedef struct packed {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] vx;
    logic [W-1:0] vy;
    logic         n1;
    logic         n2;
    logic         ny;
    logic [3:0]   nz;
    logic         cz1;
    logic         cz2;
  } side2_t;

  function automatic logic [W:0] grav_term(logic [NB-1:0] q, logic neg, logic cz,
                                           logic nz);
    logic [W:0] res;
    if (cz) begin
      res = {1'b1, nz ? {W{1'b0}} : (neg ? WMIN : WMAX)};
    end else if (neg) begin
      if (q > QMAX + NB'(1)) res = {1'b1, WMIN};
      else                   res = {1'b0, W'(-q[W-1:0])};
    end else begin
      if (q > QMAX) res = {1'b1, WMAX};
      else          res = {1'b0, q[W-1:0]};
    end
    return res;
  endfunction

  logic [MR_BITS-1:0] cfg_mass_r;
  logic [F:0]         m_c;
  logic [LAT-1:0]     vpipe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mass_r <= MR_RESET;
      vpipe_r    <= '0;
    end else begin
      if (cfg_wr_en) cfg_mass_r <= cfg_wr_data;
      vpipe_r <= {vpipe_r[LAT-2:0], start & ~busy};
    end
  end

  if (F >= MR_BITS) begin : g_mshl
    assign m_c = (F+1)'(cfg_mass_r) << (F - MR_BITS);
  end else begin : g_mshr
    assign m_c = (F+1)'(cfg_mass_r >> (MR_BITS - F));
  end

  assign busy = 1'b0;

  // Stage 1: offsets from the primaries.
  logic [W-1:0] x1_r, y1_r, vx1_r, vy1_r;
  logic [W:0]   dx1_1_r, dx2_1_r;
  logic [F:0]   m1_r, bm1_r;
  logic [F:0]   bm_nxt;

  assign bm_nxt = (F+1)'(1) << F;

  always_ff @(posedge clk) begin
    x1_r    <= in_data.pos_x;
    y1_r    <= in_data.pos_y;
    vx1_r   <= in_data.vel_x;
    vy1_r   <= in_data.vel_y;
    dx1_1_r <= {in_data.pos_x[W-1], in_data.pos_x} + (W+1)'(m_c);
    dx2_1_r <= {in_data.pos_x[W-1], in_data.pos_x} - (W+1)'(bm_nxt - m_c);
    m1_r    <= m_c;
    bm1_r   <= bm_nxt - m_c;
  end

  // Stage 2: magnitudes and signs.
  logic [W-1:0] x2_r, y2_r, vx2_r, vy2_r;
  logic [W-1:0] a1_r, a2_r, ay_r;
  logic         n1_2_r, n2_2_r, ny_2_r;
  logic [F:0]   m2_r, bm2_r;
  logic [W:0]   neg1, neg2;

  assign neg1 = -dx1_1_r;
  assign neg2 = -dx2_1_r;

  always_ff @(posedge clk) begin
    x2_r   <= x1_r;
    y2_r   <= y1_r;
    vx2_r  <= vx1_r;
    vy2_r  <= vy1_r;
    a1_r   <= dx1_1_r[W] ? neg1[W-1:0] : dx1_1_r[W-1:0];
    a2_r   <= dx2_1_r[W] ? neg2[W-1:0] : dx2_1_r[W-1:0];
    ay_r   <= y1_r[W-1] ? W'(-y1_r) : y1_r;
    n1_2_r <= dx1_1_r[W];
    n2_2_r <= dx2_1_r[W];
    ny_2_r <= y1_r[W-1];
    m2_r   <= m1_r;
    bm2_r  <= bm1_r;
  end

  // Stage 3: squares and numerators.
  logic [2*W-1:0] sq1_r, sq2_r, sqy_r;
  side_t          side3_r;

  always_ff @(posedge clk) begin
    sq1_r         <= (2*W)'(a1_r) * (2*W)'(a1_r);
    sq2_r         <= (2*W)'(a2_r) * (2*W)'(a2_r);
    sqy_r         <= (2*W)'(ay_r) * (2*W)'(ay_r);
    side3_r.x     <= x2_r;
    side3_r.y     <= y2_r;
    side3_r.vx    <= vx2_r;
    side3_r.vy    <= vy2_r;
    side3_r.n1    <= n1_2_r;
    side3_r.n2    <= n2_2_r;
    side3_r.ny    <= ny_2_r;
    side3_r.num1x <= NB'(bm2_r) * NB'(a1_r);
    side3_r.num2x <= NB'(m2_r) * NB'(a2_r);
    side3_r.num1y <= NB'(bm2_r) * NB'(ay_r);
    side3_r.num2y <= NB'(m2_r) * NB'(ay_r);
  end

  // Stage 4: squared distances.
  logic [SB-1:0] ss1_r, ss2_r;
  side_t         side4_r;

  always_ff @(posedge clk) begin
    ss1_r   <= SB'(sq1_r) + SB'(sqy_r);
    ss2_r   <= SB'(sq2_r) + SB'(sqy_r);
    side4_r <= side3_r;
  end

  logic [RW-1:0]   s1, s2;
  logic [2*SB-1:0] ssd;
  side_t           side_c;

  rtb_isqrt #(.IN_BITS(SB)) u_sqrt1 (.clk(clk), .rad(ss1_r), .root(s1));
  rtb_isqrt #(.IN_BITS(SB)) u_sqrt2 (.clk(clk), .rad(ss2_r), .root(s2));

  rtb_delay #(.WIDTH(2*SB), .DEPTH(RW)) u_dly_ss (
    .clk(clk), .din({ss1_r, ss2_r}), .dout(ssd)
  );

  rtb_delay #(.WIDTH($bits(side_t)), .DEPTH(RW+2)) u_dly_side (
    .clk(clk), .din(side4_r), .dout(side_c)
  );

  // Partial products of the cubed distance.
  logic [DB-1:0]         d1, d2;
  logic [HALF+RW-1:0]    plo1_r, plo2_r;
  logic [DB-HALF+RW-1:0] phi1_r, phi2_r;

  assign d1 = ssd[2*SB-1:SB+F];
  assign d2 = ssd[SB-1:F];

  always_ff @(posedge clk) begin
    plo1_r <= (HALF+RW)'(d1[HALF-1:0]) * (HALF+RW)'(s1);
    plo2_r <= (HALF+RW)'(d2[HALF-1:0]) * (HALF+RW)'(s2);
    phi1_r <= (DB-HALF+RW)'(d1[DB-1:HALF]) * (DB-HALF+RW)'(s1);
    phi2_r <= (DB-HALF+RW)'(d2[DB-1:HALF]) * (DB-HALF+RW)'(s2);
  end

  logic [PW-1:0]  full1, full2;
  logic [DEN-1:0] cube1_nxt, cube2_nxt;
  logic [DEN-1:0] cube1_r, cube2_r;

  assign full1 = PW'(plo1_r) + (PW'(phi1_r) << HALF);
  assign full2 = PW'(plo2_r) + (PW'(phi2_r) << HALF);

  if (CB > 64) begin : g_csat
    assign cube1_nxt = (|full1[PW-1:F+64]) ? '1 : full1[F+63:F];
    assign cube2_nxt = (|full2[PW-1:F+64]) ? '1 : full2[F+63:F];
  end else begin : g_cfit
    assign cube1_nxt = full1[PW-1:F];
    assign cube2_nxt = full2[PW-1:F];
  end

  always_ff @(posedge clk) begin
    cube1_r <= cube1_nxt;
    cube2_r <= cube2_nxt;
  end

  logic [NB-1:0] q1x, q2x, q1y, q2y;

  rtb_udiv #(.NUM_BITS(NB), .DEN_BITS(DEN)) u_div1x (
    .clk(clk), .num(side_c.num1x), .den(cube1_r), .quo(q1x)
  );
  rtb_udiv #(.NUM_BITS(NB), .DEN_BITS(DEN)) u_div2x (
    .clk(clk), .num(side_c.num2x), .den(cube2_r), .quo(q2x)
  );
  rtb_udiv #(.NUM_BITS(NB), .DEN_BITS(DEN)) u_div1y (
    .clk(clk), .num(side_c.num1y), .den(cube1_r), .quo(q1y)
  );
  rtb_udiv #(.NUM_BITS(NB), .DEN_BITS(DEN)) u_div2y (
    .clk(clk), .num(side_c.num2y), .den(cube2_r), .quo(q2y)
  );

  side2_t side2_c, side_g;

  always_comb begin
    side2_c.x   = side_c.x;
    side2_c.y   = side_c.y;
    side2_c.vx  = side_c.vx;
    side2_c.vy  = side_c.vy;
    side2_c.n1  = side_c.n1;
    side2_c.n2  = side_c.n2;
    side2_c.ny  = side_c.ny;
    side2_c.nz  = {side_c.num1x == '0, side_c.num2x == '0,
                   side_c.num1y == '0, side_c.num2y == '0};
    side2_c.cz1 = cube1_r == '0;
    side2_c.cz2 = cube2_r == '0;
  end

  rtb_delay #(.WIDTH($bits(side2_t)), .DEPTH(NB)) u_dly_side2 (
    .clk(clk), .din(side2_c), .dout(side_g)
  );

  // Gravity terms with clamping.
  logic [W:0]   t1x, t2x, t1y, t2y;
  logic [W-1:0] g1x_r, g2x_r, g1y_r, g2y_r;
  logic [W-1:0] xg_r, yg_r, vxg_r, vyg_r;
  logic         flag_g_r;

  assign t1x = grav_term(q1x, side_g.n1, side_g.cz1, side_g.nz[3]);
  assign t2x = grav_term(q2x, side_g.n2, side_g.cz2, side_g.nz[2]);
  assign t1y = grav_term(q1y, side_g.ny, side_g.cz1, side_g.nz[1]);
  assign t2y = grav_term(q2y, side_g.ny, side_g.cz2, side_g.nz[0]);

  always_ff @(posedge clk) begin
    g1x_r    <= t1x[W-1:0];
    g2x_r    <= t2x[W-1:0];
    g1y_r    <= t1y[W-1:0];
    g2y_r    <= t2y[W-1:0];
    flag_g_r <= t1x[W] | t2x[W] | t1y[W] | t2y[W];
    xg_r     <= side_g.x;
    yg_r     <= side_g.y;
    vxg_r    <= side_g.vx;
    vyg_r    <= side_g.vy;
  end

  // Final sums.
  logic [W+2:0] sum_x, sum_y;
  logic         ovf_x, ovf_y;
  out_t         out_r;

  assign sum_x = (W+3)'($signed(xg_r)) + ((W+3)'($signed(vyg_r)) << 1)
               - (W+3)'($signed(g1x_r)) - (W+3)'($signed(g2x_r));
  assign sum_y = (W+3)'($signed(yg_r)) - ((W+3)'($signed(vxg_r)) << 1)
               - (W+3)'($signed(g1y_r)) - (W+3)'($signed(g2y_r));
  assign ovf_x = !((&sum_x[W+2:W-1]) || (sum_x[W+2:W-1] == '0));
  assign ovf_y = !((&sum_y[W+2:W-1]) || (sum_y[W+2:W-1] == '0));

  always_ff @(posedge clk) begin
    out_r.rate_x    <= vxg_r;
    out_r.rate_y    <= vyg_r;
    out_r.accel_x   <= ovf_x ? (sum_x[W+2] ? WMIN : WMAX) : sum_x[W-1:0];
    out_r.accel_y   <= ovf_y ? (sum_y[W+2] ? WMIN : WMAX) : sum_y[W-1:0];
    out_r.saturated <= flag_g_r | ovf_x | ovf_y;
  end

  assign out_valid = vpipe_r[LAT-1];
  assign out_data  = out_r;

  `RTB_ASSERT(a_latency, clk, rst_n, start && !busy |-> ##LAT out_valid, "result strobe missing")
  `RTB_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> vpipe_r == '0, "valid pipeline not cleared")
  `RTB_ASSERT(a_zero_cube, clk, rst_n, vpipe_r[LAT-3] && (side_g.cz1 || side_g.cz2) |=> ##1 out_data.saturated, "zero distance not flagged")

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Restricted three-body derivative testbench
// Drives state vectors into the derivative block and compares each result with
// a typed expectation or an in-bench fixed-point model of the rotating-frame
// equations of motion. The run covers several mass ratios and random input gaps.
// ----------------------------------------------------------------------------
module testbench
  import rtb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY_WAIT = 110;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint signed WORD_MAX = 64'sd2147483647;
  localparam longint signed WORD_MIN = -64'sd2147483648;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t result;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_t                in_data;
  logic               out_valid;
  out_t               out_data;
  logic               cfg_wr_en;
  logic [MR_BITS-1:0] cfg_wr_data;

  logic [MR_BITS-1:0] mass_ratio_now;
  bit                 row_typed;
  out_t               row_result;
  out_t               pending_derivs[$];
  int                 error_count;
  int                 cycle_count;

  restricted_three_body_derivative uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint signed v);
    return (v < 0) ? longint'(0) - longint'(v) : longint'(v);
  endfunction

  function automatic longint unsigned cubed_distance(longint signed dx, longint signed dy);
    bit [127:0]      sq;
    bit [127:0]      dsq;
    bit [127:0]      cube;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned root;
    longint unsigned cand;
    ax = magnitude(dx);
    ay = magnitude(dy);
    sq = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= sq) root = cand;
    end
    dsq = sq >> FRAC_BITS;
    if (dsq[127:64] != 0) return '1;
    cube = ({64'd0, dsq[63:0]} * {64'd0, root}) >> FRAC_BITS;
    if (cube[127:64] != 0) return '1;
    return cube[63:0];
  endfunction

  function automatic longint signed gravity_term(longint unsigned mass, longint signed off,
                                                 longint unsigned cube, inout bit flag);
    longint unsigned num;
    longint unsigned q;
    num = mass * magnitude(off);
    if (cube == 0) begin
      flag = 1'b1;
      if (num == 0) return 0;
      return (off < 0) ? WORD_MIN : WORD_MAX;
    end
    q = num / cube;
    if (off < 0) begin
      if (q > longint'(WORD_MAX) + 1) begin
        flag = 1'b1;
        return WORD_MIN;
      end
      return -longint'(q);
    end
    if (q > longint'(WORD_MAX)) begin
      flag = 1'b1;
      return WORD_MAX;
    end
    return longint'(q);
  endfunction

  function automatic longint signed clamp_word(longint signed v, inout bit flag);
    if (v > WORD_MAX) begin
      flag = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      flag = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  function automatic out_t derive_state(in_t s, logic [MR_BITS-1:0] mr);
    out_t            r;
    bit              flag;
    longint signed   x;
    longint signed   y;
    longint signed   vx;
    longint signed   vy;
    longint unsigned m;
    longint unsigned big_m;
    longint signed   dx1;
    longint signed   dx2;
    longint unsigned c1;
    longint unsigned c2;
    longint signed   g1x;
    longint signed   g2x;
    longint signed   g1y;
    longint signed   g2y;
    flag = 1'b0;
    x = s.pos_x;
    y = s.pos_y;
    vx = s.vel_x;
    vy = s.vel_y;
    m = {40'd0, mr};
    big_m = ONE_Q - m;
    dx1 = x + longint'(m);
    dx2 = x - longint'(big_m);
    c1 = cubed_distance(dx1, y);
    c2 = cubed_distance(dx2, y);
    g1x = gravity_term(big_m, dx1, c1, flag);
    g2x = gravity_term(m, dx2, c2, flag);
    g1y = gravity_term(big_m, y, c1, flag);
    g2y = gravity_term(m, y, c2, flag);
    r.rate_x = s.vel_x;
    r.rate_y = s.vel_y;
    r.accel_x = WORD_BITS'(clamp_word(x + 2 * vy - g1x - g2x, flag));
    r.accel_y = WORD_BITS'(clamp_word(y - 2 * vx - g1y - g2y, flag));
    r.saturated = flag;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && cfg_wr_en) mass_ratio_now <= cfg_wr_data;
    if (rst_n && start && !busy) begin
      pending_derivs.push_back(row_typed ? row_result : derive_state(in_data, mass_ratio_now));
    end
    if (rst_n && out_valid) begin
      if (pending_derivs.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < 10) $display("Unexpected transaction: %h", out_data);
      end else begin
        want = pending_derivs.pop_front();
        if (want.rate_x !== out_data.rate_x || want.rate_y !== out_data.rate_y ||
            want.accel_x !== out_data.accel_x || want.accel_y !== out_data.accel_y ||
            want.saturated !== out_data.saturated) begin
          error_count <= error_count + 1;
          if (error_count < 10) begin
            $display("Mismatch: expected rate %h %h accel %h %h sat %b",
                     want.rate_x, want.rate_y, want.accel_x, want.accel_y, want.saturated);
            $display("          actual   rate %h %h accel %h %h sat %b",
                     out_data.rate_x, out_data.rate_y, out_data.accel_x,
                     out_data.accel_y, out_data.saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  int burst_left;

  task automatic send_state(in_t s, bit typed, out_t result);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    in_data <= s;
    row_typed <= typed;
    row_result <= result;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      burst_left = 40;
      gap = 0;
    end else if ($urandom_range(0, 9) < 6) gap = 0;
    else if ($urandom_range(0, 9) < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      row_typed <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    row_typed <= 1'b0;
    while (pending_derivs.size() != 0) @(negedge clk);
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  task automatic write_mass_ratio(logic [MR_BITS-1:0] value);
    drain_pipeline();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [WORD_BITS-1:0] near_range();
    return WORD_BITS'($urandom_range(0, 6 << FRAC_BITS)) - WORD_BITS'(3 << FRAC_BITS);
  endfunction

  function automatic in_t random_state();
    in_t             s;
    int              kind;
    longint signed   off;
    kind = $urandom_range(0, 9);
    s.vel_x = near_range();
    s.vel_y = near_range();
    if (kind < 2) begin
      s = {$urandom(), $urandom(), $urandom(), $urandom()};
    end else if (kind < 7) begin
      s.pos_x = near_range();
      s.pos_y = near_range();
    end else if (kind < 9) begin
      off = longint'($urandom_range(0, 1 << $urandom_range(0, 22))) -
            longint'($urandom_range(0, 1 << $urandom_range(0, 22)));
      if ($urandom_range(0, 1) == 0) s.pos_x = WORD_BITS'(-longint'(mass_ratio_now) + off);
      else s.pos_x = WORD_BITS'(longint'(ONE_Q) - longint'(mass_ratio_now) + off);
      s.pos_y = WORD_BITS'(longint'($urandom_range(0, 1 << $urandom_range(0, 22))) -
                           longint'($urandom_range(0, 1 << $urandom_range(0, 22))));
    end else begin
      s.pos_x = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      s.pos_y = near_range();
      s.vel_y = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      s.vel_x = $urandom();
    end
    return s;
  endfunction

  stim_row_t directed_rows[$];
  out_t      no_result;

  initial begin
    logic [MR_BITS-1:0] mass_settings[$];
    stim_row_t          row;
    start = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    row_typed = 1'b0;
    row_result = '0;
    no_result = '0;
    burst_left = 0;
    error_count = 0;
    cycle_count = 0;
    mass_ratio_now = MR_RESET;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Rest at the origin, on each primary with zero velocity, near a primary
    // at sub-resolution and small offsets, and the word extremes.
    directed_rows = '{
      '{'{32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{-32'sd205982, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{'{32'h00fcdb62, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{'{-32'sd205981, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{-32'sd205983, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{-32'sd205982, 32'h1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{-32'sd201886, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h00fcdb62, 32'h00001000, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h00fcdb63, 32'hffffffff, 32'h7fffffff, 32'h80000000}, 1'b0, '0},
      '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 1'b0, '0},
      '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, '0},
      '{'{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff}, 1'b0, '0},
      '{'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff}, 1'b0, '0},
      '{'{32'h00d8a000, 32'h00400000, 32'hff800000, 32'h01000000}, 1'b0, '0},
      '{'{32'h01000000, 32'h00000000, 32'h00000000, 32'h00000000}, 1'b0, '0},
      '{'{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa}, 1'b0, '0},
      '{'{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555}, 1'b0, '0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_state(row.stim, row.typed, row.result);
    end

    mass_settings = '{24'd0, 24'd8388608, 24'($urandom_range(1, 8388607)), 24'd1, MR_RESET};
    for (int p = 0; p <= mass_settings.size(); p++) begin
      if (p > 0) write_mass_ratio(mass_settings[p - 1]);
      repeat (105) send_state(random_state(), 1'b0, no_result);
    end

    drain_pipeline();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
